/* rtl/core/stok_pkg.sv */
package stok_pkg;

  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChBslash = 8'h5C;

  localparam logic [1:0] QmNone   = 2'd0;
  localparam logic [1:0] QmSingle = 2'd1;
  localparam logic [1:0] QmDouble = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       line_last;
  } tok_in_t;

  typedef struct packed {
    logic       lead_backslash;
    logic       append_byte;
    logic [7:0] byte_out;
    logic       token_done;
    logic       line_done;
  } tok_out_t;

  typedef struct packed {
    logic [1:0] quote_mode;
    logic       escape_pending;
    logic       token_open;
  } tok_state_t;

  localparam tok_state_t StateReset = '{quote_mode: QmNone, escape_pending: 1'b0,
                                        token_open: 1'b0};

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

endpackage

/* rtl/core/stok_ifs.sv */
interface stok_in_if import stok_pkg::*; ();
  logic    valid;
  logic    ready;
  tok_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface stok_out_if import stok_pkg::*; ();
  logic     valid;
  logic     ready;
  tok_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/shell_style_tokenizer_unit.sv */
// Shell-style tokenizer: one command-line byte in, one token action out.
//
// in_ch_i  (sink): one beat per byte, payload in_byte and line_last. Set
//   line_last on the final byte of each line; empty lines are not sent.
// out_ch_o (source): one beat per input beat, in order: lead_backslash,
//   append_byte, byte_out, token_done, line_done.
//
// A byte lands in the input register, the step logic decodes it against the
// quote/escape state, and the result register holds the action. Throughput
// is one byte per cycle while out_ch_o.ready stays high; the state update is
// a single small decode, so nothing limits the rate but the handshake.
//
// Reset clears both register stages and the tokenizer state (outside quotes,
// no pending escape, no open token). When out_ch_o.ready is low the result
// register holds and the input register can still take one more byte; only
// when both are full does in_ch_i.ready drop.
module shell_style_tokenizer_unit import stok_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  stok_in_if.sink    in_ch_i,
  stok_out_if.source out_ch_o
);

  logic       in_valid_q;
  tok_in_t    in_item_q;
  logic       out_valid_q;
  tok_out_t   out_res_q;
  tok_state_t state_q, state_d;
  tok_out_t   res_d;
  logic       advance;

  assign advance       = in_valid_q && (!out_valid_q || out_ch_o.ready);
  assign in_ch_i.ready = !in_valid_q || advance;

  stok_step u_step (
    .state_i (state_q),
    .item_i  (in_item_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= StateReset;
    end else begin
      if (in_ch_i.ready) begin
        in_valid_q <= in_ch_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_ch_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch_i.ready && in_ch_i.valid) begin
      in_item_q <= in_ch_i.data;
    end
    if (advance) begin
      out_res_q <= res_d;
    end
  end

  assign out_ch_o.valid = out_valid_q;
  assign out_ch_o.data  = out_res_q;

endmodule

/* rtl/core/stok_step.sv */
module stok_step import stok_pkg::*; (
  input  tok_state_t state_i,
  input  tok_in_t    item_i,
  output tok_state_t state_o,
  output tok_out_t   res_o
);

  logic [7:0] c;
  logic [7:0] qc;
  logic       quoted;
  tok_state_t nxt;

  assign c      = item_i.in_byte;
  assign quoted = (state_i.quote_mode == QmSingle) || (state_i.quote_mode == QmDouble);
  assign qc     = (state_i.quote_mode == QmDouble) ? ChDquote : ChSquote;

  always_comb begin
    nxt   = state_i;
    res_o = '0;
    if (!quoted) begin
      nxt.quote_mode     = QmNone;
      nxt.escape_pending = 1'b0;
      if (is_space(c)) begin
        if (state_i.token_open) begin
          res_o.token_done = 1'b1;
          nxt.token_open   = 1'b0;
        end
      end else if (c == ChDquote) begin
        nxt.quote_mode = QmDouble;
        nxt.token_open = 1'b1;
      end else if (c == ChSquote) begin
        nxt.quote_mode = QmSingle;
        nxt.token_open = 1'b1;
      end else begin
        res_o.append_byte = 1'b1;
        res_o.byte_out    = c;
        nxt.token_open    = 1'b1;
      end
    end else begin
      nxt.token_open = 1'b1;
      if (state_i.escape_pending) begin
        nxt.escape_pending   = 1'b0;
        res_o.lead_backslash = (c != qc) && (c != ChBslash);
        res_o.append_byte    = 1'b1;
        res_o.byte_out       = c;
      end else if (c == qc) begin
        nxt.quote_mode = QmNone;
      end else if ((c == ChBslash) && !item_i.line_last) begin
        nxt.escape_pending = 1'b1;
      end else begin
        res_o.append_byte = 1'b1;
        res_o.byte_out    = c;
      end
    end

    if (item_i.line_last) begin
      if (nxt.token_open) begin
        res_o.token_done = 1'b1;
      end
      res_o.line_done = 1'b1;
      nxt = StateReset;
    end
    state_o = nxt;
  end

endmodule

/* rtl/core/stok_checker.sv */
module stok_checker import stok_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_i,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input tok_out_t out_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("result payload changed while stalled");

  a_stall_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input blocked without output backpressure");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |-> ##2 out_valid_i)
    else $error("accepted byte gave no result after two cycles");

endmodule

bind shell_style_tokenizer_unit stok_checker u_stok_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch_i.valid),
  .in_ready_i  (in_ch_i.ready),
  .out_valid_i (out_ch_o.valid),
  .out_ready_i (out_ch_o.ready),
  .out_data_i  (out_ch_o.data)
);

/* tb/sv/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import stok_pkg::*;

  typedef logic [7:0] char_q_t[$];

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChFf    = 8'h0C;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChX     = 8'h78;
  localparam logic [7:0] ChTop   = 8'hFF;

  logic clk_i;
  logic rst_ni;

  stok_in_if  in_ch ();
  stok_out_if out_ch ();

  shell_style_tokenizer_unit DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch_i (in_ch),
    .out_ch_o(out_ch)
  );

  // tokenizer state as the testbench tracks it
  logic [1:0] quote_st;
  logic       esc_st;
  logic       open_st;

  tok_out_t pending_actions[$];
  int       mismatch_count;
  bit       no_gaps;
  int       stall_left;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic tok_out_t tokenize_step(tok_in_t beat);
    tok_out_t   act;
    logic [7:0] c;
    logic [7:0] closer;
    act = '0;
    c = beat.in_byte;
    if (quote_st != QmSingle && quote_st != QmDouble) begin
      quote_st = QmNone;
      esc_st = 1'b0;
      if (c == ChSpace || (c >= ChTab && c <= ChCr)) begin
        if (open_st) begin
          act.token_done = 1'b1;
          open_st = 1'b0;
        end
      end else if (c == ChDquote) begin
        quote_st = QmDouble;
        open_st = 1'b1;
      end else if (c == ChSquote) begin
        quote_st = QmSingle;
        open_st = 1'b1;
      end else begin
        act.append_byte = 1'b1;
        act.byte_out = c;
        open_st = 1'b1;
      end
    end else begin
      closer = (quote_st == QmDouble) ? ChDquote : ChSquote;
      open_st = 1'b1;
      if (esc_st) begin
        esc_st = 1'b0;
        act.lead_backslash = (c != closer) && (c != ChBslash);
        act.append_byte = 1'b1;
        act.byte_out = c;
      end else if (c == closer) begin
        quote_st = QmNone;
      end else if (c == ChBslash && !beat.line_last) begin
        esc_st = 1'b1;
      end else begin
        act.append_byte = 1'b1;
        act.byte_out = c;
      end
    end
    if (beat.line_last) begin
      if (open_st) act.token_done = 1'b1;
      act.line_done = 1'b1;
      quote_st = QmNone;
      esc_st = 1'b0;
      open_st = 1'b0;
    end
    return act;
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic last);
    int      gap;
    tok_in_t beat;
    gap = pick_gap();
    beat.in_byte = c;
    beat.line_last = last;
    @(negedge clk_i);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= beat;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_actions = {pending_actions, tokenize_step(beat)};
  endtask

  task automatic send_line(input char_q_t chars);
    foreach (chars[i]) send_byte(chars[i], i == chars.size() - 1);
  endtask

  function automatic logic [7:0] word_char();
    return 8'($urandom_range(8'h21, 8'h7E));
  endfunction

  // mostly words, quoted spans with escapes and blanks; some raw noise
  function automatic char_q_t build_line();
    char_q_t    chars;
    int         pieces;
    int         r;
    logic [7:0] q;
    chars = {};
    pieces = ($urandom_range(0, 19) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 4);
    repeat (pieces) begin
      r = $urandom_range(0, 9);
      if (r < 3) begin
        repeat ($urandom_range(1, 4)) chars = {chars, word_char()};
      end else if (r < 6) begin
        q = $urandom_range(0, 1) ? ChDquote : ChSquote;
        chars = {chars, q};
        repeat ($urandom_range(0, 4)) begin
          case ($urandom_range(0, 9))
            0, 1: begin
              chars = {chars, ChBslash};
              case ($urandom_range(0, 2))
                0: chars = {chars, q};
                1: chars = {chars, ChBslash};
                default: chars = {chars, 8'($urandom_range(0, 255))};
              endcase
            end
            2: chars = {chars, ((q == ChDquote) ? ChSquote : ChDquote)};
            3: chars = {chars, 8'($urandom_range(0, 255))};
            default: chars = {chars, word_char()};
          endcase
        end
        if ($urandom_range(0, 6) != 0) chars = {chars, q};
      end else if (r < 8) begin
        repeat ($urandom_range(1, 2)) begin
          case ($urandom_range(0, 5))
            0: chars = {chars, ChSpace};
            1: chars = {chars, ChTab};
            2: chars = {chars, ChLf};
            3: chars = {chars, ChVt};
            4: chars = {chars, ChFf};
            default: chars = {chars, ChCr};
          endcase
        end
      end else begin
        repeat ($urandom_range(1, 3)) chars = {chars, 8'($urandom_range(0, 255))};
      end
    end
    return chars;
  endfunction

  task automatic test_plain_bytes();
    send_line('{ChNul, ChBslash, ChSpace, ChTop, ChTab, ChCr});
    send_line('{ChLf, ChVt, ChFf});
  endtask

  task automatic test_quoted_spans();
    send_line('{ChDquote, ChDquote, ChSpace, ChSquote, ChSquote});
    // escapes, other quote inside, dangling backslash, unclosed at line end
    send_line('{ChDquote, ChBslash, ChDquote, ChBslash, ChBslash, ChBslash, ChX,
                ChSquote, ChBslash});
    send_line('{ChSquote, ChBslash, ChSquote});
  endtask

  task automatic test_random_lines(input int n_bytes, input bit full_rate);
    char_q_t chars;
    int      sent;
    sent = 0;
    no_gaps = full_rate;
    while (sent < n_bytes) begin
      chars = build_line();
      send_line(chars);
      sent += chars.size();
    end
    no_gaps = 1'b0;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t %s: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    tok_out_t want;
    tok_out_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_actions.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected beat: expected none, actual %0h", $time, got);
      end else begin
        want = pending_actions.pop_front();
        check_field("lead_backslash", want.lead_backslash, got.lead_backslash);
        check_field("append_byte", want.append_byte, got.append_byte);
        check_field("byte_out", want.byte_out, got.byte_out);
        check_field("token_done", want.token_done, got.token_done);
        check_field("line_done", want.line_done, got.line_done);
      end
    end
  end

  initial begin
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0 && !no_gaps) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = 0;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin
    #2_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    quote_st = QmNone;
    esc_st = 1'b0;
    open_st = 1'b0;
    mismatch_count = 0;
    no_gaps = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_plain_bytes();
    test_quoted_spans();
    test_random_lines(120, 1'b1);
    test_random_lines(730, 1'b0);

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_actions.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/stok_pkg.sv
rtl/core/stok_ifs.sv
rtl/core/stok_step.sv
rtl/core/shell_style_tokenizer_unit.sv
rtl/core/stok_checker.sv
tb/sv/testbench.sv
